// ===== rtl/core/adist_pkg.sv =====
`timescale 1ns / 1ps

package adist_pkg;

  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 7;
  localparam int INDEX_W  = 2;

  localparam logic [SAMPLE_W-1:0] MID_CODE = 8'd127;

  // overdrive knee and output swing around the midpoint
  localparam logic signed [11:0] KNEE  = 12'sd100;
  localparam logic signed [11:0] SWING = 12'sd127;

  typedef enum logic [1:0] {
    KIND_CLIP      = 2'd0,
    KIND_OVERDRIVE = 2'd1,
    KIND_FUZZ      = 2'd2
  } kind_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_LEVEL  = 2'd1,
    REG_KIND   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic               enable;
    logic [LEVEL_W-1:0] level;
    kind_t              kind;
  } cfg_t;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;

  // gain = 1 + level*9/255, by thresholds (smallest level reaching each step)
  localparam int GAIN_T1 = (255 * 1 + 8) / 9;
  localparam int GAIN_T2 = (255 * 2 + 8) / 9;
  localparam int GAIN_T3 = (255 * 3 + 8) / 9;
  localparam int GAIN_T4 = (255 * 4 + 8) / 9;

  function automatic logic [2:0] drive_gain(logic [LEVEL_W-1:0] level);
    logic [2:0] g;
    g = 3'd1;
    if (level >= LEVEL_W'(GAIN_T1)) g = 3'd2;
    if (level >= LEVEL_W'(GAIN_T2)) g = 3'd3;
    if (level >= LEVEL_W'(GAIN_T3)) g = 3'd4;
    if (level >= LEVEL_W'(GAIN_T4)) g = 3'd5;
    return g;
  endfunction

endpackage

// ===== rtl/core/audio_distortion_effect.sv =====
`timescale 1ns / 1ps

// Distortion effect for unsigned 8-bit audio samples, midpoint 127.
// Sample channel: a sample is taken on a rising edge with start high and busy
// low. busy is only high during reset, so a new sample may be given every cycle.
// Result channel: done pulses for one cycle with sample_out valid; each start
// gives exactly one done, through the input register and then the result
// register, in order. The receiver has no way to stall and must take it.
// Throughput is one sample per cycle; the shaping logic between the two
// registers is one small 9x3 multiply plus compares and a select.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
// Index 0 enable, 1 drive level (0..LEVEL_LIMIT), 2 kind (low bits: clip,
// overdrive, fuzz). Out-of-range levels, kind 3 and unknown indexes are dropped.
// Only write while no sample is in flight.
// Reset (rst, synchronous): pipeline emptied, enable off, level 50, hard clip.

module audio_distortion_effect #(
  parameter int LEVEL_LIMIT = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [adist_pkg::SAMPLE_W-1:0]      sample_in,
  output logic                                done,
  output logic [adist_pkg::SAMPLE_W-1:0]      sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adist_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [adist_pkg::LEVEL_W-1:0]       cfg_data
);

  adist_pkg::cfg_t               cfg;
  logic                          in_valid;
  logic [adist_pkg::SAMPLE_W-1:0] in_sample;
  logic [adist_pkg::SAMPLE_W-1:0] shaped;
  logic                          take;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  adist_cfg #(
    .LEVEL_LIMIT(LEVEL_LIMIT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= take;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_sample <= sample_in;
    if (in_valid) sample_out <= shaped;
  end

  adist_shaper u_shaper (
    .cfg   (cfg),
    .sample(in_sample),
    .shaped(shaped)
  );

  a_done_after_take: assert property (@(posedge clk) disable iff (rst)
    take |-> ##2 done)
    else $error("accepted sample produced no result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2) && !$past(busy, 2))
    else $error("result with no accepted sample");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    done && !cfg.enable |-> sample_out == $past(sample_in, 2))
    else $error("bypass altered the sample");

  a_clip_window: assert property (@(posedge clk) disable iff (rst)
    done && cfg.enable && cfg.kind == adist_pkg::KIND_CLIP |->
      sample_out >= 8'(cfg.level) && sample_out <= 8'd254 - 8'(cfg.level))
    else $error("hard clip outside its window");

endmodule

// ===== rtl/core/adist_cfg.sv =====
`timescale 1ns / 1ps

module adist_cfg #(
  parameter int LEVEL_LIMIT = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [adist_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [adist_pkg::LEVEL_W-1:0]       cfg_data,
  output adist_pkg::cfg_t                     cfg
);

  logic wr;
  assign wr = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.level  <= adist_pkg::LEVEL_RESET;
      cfg.kind   <= adist_pkg::KIND_CLIP;
    end else if (wr) begin
      case (adist_pkg::reg_idx_t'(cfg_index))
        adist_pkg::REG_ENABLE: cfg.enable <= cfg_data[0];
        adist_pkg::REG_LEVEL: begin
          if (cfg_data <= adist_pkg::LEVEL_W'(LEVEL_LIMIT)) cfg.level <= cfg_data;
        end
        adist_pkg::REG_KIND: begin
          // the unused kind code is dropped
          if (cfg_data[1:0] <= 2'(adist_pkg::KIND_FUZZ)) begin
            cfg.kind <= adist_pkg::kind_t'(cfg_data[1:0]);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/adist_shaper.sv =====
`timescale 1ns / 1ps

module adist_shaper (
  input  adist_pkg::cfg_t                  cfg,
  input  logic [adist_pkg::SAMPLE_W-1:0]   sample,
  output logic [adist_pkg::SAMPLE_W-1:0]   shaped
);

  logic [7:0]         clip_lo, clip_hi, clip_r;
  logic [7:0]         fuzz_span, fuzz_lo, fuzz_hi, fuzz_r;
  logic [2:0]         gain;
  logic signed [8:0]  centred;
  logic signed [11:0] centred_x, gain_x, prod, comp, sat;
  logic [7:0]         od_r;

  // hard clip window is [level, 254 - level]
  always_comb begin
    clip_lo = 8'(cfg.level);
    clip_hi = 8'd254 - 8'(cfg.level);
    if (sample > clip_hi)      clip_r = clip_hi;
    else if (sample < clip_lo) clip_r = clip_lo;
    else                       clip_r = sample;
  end

  always_comb begin
    fuzz_span = (8'd255 - 8'(cfg.level)) >> 2;
    fuzz_hi   = adist_pkg::MID_CODE + fuzz_span;
    fuzz_lo   = adist_pkg::MID_CODE - fuzz_span;
    if (sample > fuzz_hi)      fuzz_r = 8'd255;
    else if (sample < fuzz_lo) fuzz_r = 8'd0;
    else                       fuzz_r = sample;
  end

  always_comb begin
    gain      = adist_pkg::drive_gain(cfg.level);
    centred   = signed'({1'b0, sample}) - 9'sd127;
    centred_x = 12'(centred);
    gain_x    = signed'(12'(gain));
    prod      = centred_x * gain_x;
    // excess beyond the knee is quartered, truncating toward zero
    if (prod > adist_pkg::KNEE) begin
      comp = adist_pkg::KNEE + ((prod - adist_pkg::KNEE) >>> 2);
    end else if (prod < -adist_pkg::KNEE) begin
      comp = -adist_pkg::KNEE - ((-(prod + adist_pkg::KNEE)) >>> 2);
    end else begin
      comp = prod;
    end
    if (comp > adist_pkg::SWING)       sat = adist_pkg::SWING;
    else if (comp < -adist_pkg::SWING) sat = -adist_pkg::SWING;
    else                               sat = comp;
    od_r = 8'(sat + adist_pkg::SWING);
  end

  always_comb begin
    if (!cfg.enable) begin
      shaped = sample;
    end else begin
      case (cfg.kind)
        adist_pkg::KIND_CLIP:      shaped = clip_r;
        adist_pkg::KIND_OVERDRIVE: shaped = od_r;
        adist_pkg::KIND_FUZZ:      shaped = fuzz_r;
        default:                   shaped = sample;
      endcase
    end
  end

endmodule

// ===== tb/audio_distortion_effect_tb.sv =====
`timescale 1ns / 1ps

module audio_distortion_effect_tb;

  localparam int LEVEL_LIMIT = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 75;
  localparam logic [adist_pkg::INDEX_W-1:0] REG_NONE = 2'd3;
  localparam logic [1:0]                    KIND_BAD = 2'd3;

  typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_t;

  typedef struct packed {
    step_t                          op;
    logic [adist_pkg::INDEX_W-1:0]  idx;
    logic [adist_pkg::LEVEL_W-1:0]  data;
    logic [adist_pkg::SAMPLE_W-1:0] smp;
    logic [adist_pkg::SAMPLE_W-1:0] want;
    logic                           known;
  } step_row_t;

  localparam int SCRIPT_LEN = 39;

  // passthrough after reset, then clip at levels 50 and 100, overdrive and fuzz at levels 100 and 0
  step_row_t script [0:SCRIPT_LEN-1] = '{
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd0,   8'd0,   1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd255, 1'b1},
    '{STEP_WRITE,  adist_pkg::REG_ENABLE, 7'd1,   8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd204, 1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd0,   8'd50,  1'b1},
    '{STEP_WRITE,  adist_pkg::REG_LEVEL,  7'd100, 8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd154, 1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd0,   8'd100, 1'b1},
    '{STEP_WRITE,  adist_pkg::REG_LEVEL,  7'd101, 8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd154, 1'b1},
    '{STEP_WRITE,  adist_pkg::REG_LEVEL,  7'd127, 8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd130, 8'd0,   1'b0},
    '{STEP_WRITE,  adist_pkg::REG_KIND,   7'(adist_pkg::KIND_OVERDRIVE), 8'd0, 8'd0, 1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd254, 1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd0,   8'd0,   1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd155, 8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd101, 8'd0,   1'b0},
    '{STEP_WRITE,  adist_pkg::REG_KIND,   7'(KIND_BAD), 8'd0, 8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd102, 8'd0,   1'b0},
    '{STEP_WRITE,  adist_pkg::REG_LEVEL,  7'd0,   8'd0,   8'd0,   1'b0},
    // excess of -5 divides to -1, not -2
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd22,  8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd0,   1'b0},
    '{STEP_WRITE,  adist_pkg::REG_KIND,   7'(adist_pkg::KIND_FUZZ), 8'd0, 8'd0,  1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd191, 8'd255, 1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd190, 8'd190, 1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd63,  8'd0,   1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd64,  8'd64,  1'b1},
    '{STEP_WRITE,  REG_NONE,              7'd127, 8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd255, 8'd255, 1'b1},
    // only bit 0 of the enable write counts
    '{STEP_WRITE,  adist_pkg::REG_ENABLE, 7'd2,   8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd200, 8'd200, 1'b1},
    '{STEP_WRITE,  adist_pkg::REG_ENABLE, 7'd127, 8'd0,   8'd0,   1'b0},
    '{STEP_WRITE,  adist_pkg::REG_LEVEL,  7'd100, 8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd165, 8'd165, 1'b1},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd166, 8'd255, 1'b1},
    '{STEP_WRITE,  adist_pkg::REG_KIND,   7'd6,   8'd0,   8'd0,   1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd88,  8'd0,   1'b1},
    '{STEP_WRITE,  adist_pkg::REG_KIND,   7'(adist_pkg::KIND_CLIP), 8'd0, 8'd0,  1'b0},
    '{STEP_SAMPLE, REG_NONE,              7'd0,   8'd170, 8'd154, 1'b1}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [adist_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic                           done;
  logic [adist_pkg::SAMPLE_W-1:0] sample_out;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [adist_pkg::INDEX_W-1:0]  cfg_index = '0;
  logic [adist_pkg::LEVEL_W-1:0]  cfg_data = '0;

  // mirror of the effect registers
  logic                           fx_enable;
  logic [adist_pkg::LEVEL_W-1:0]  fx_level;
  adist_pkg::kind_t               fx_kind;

  logic [adist_pkg::SAMPLE_W-1:0] pending_samples[$];
  int                             faults;
  int                             samples_checked;
  int                             writes_done;
  int                             cycles;
  bit                             gaps_on;

  audio_distortion_effect #(.LEVEL_LIMIT(LEVEL_LIMIT)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .done       (done),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [adist_pkg::SAMPLE_W-1:0] distort(
      logic [adist_pkg::SAMPLE_W-1:0] s, logic en,
      logic [adist_pkg::LEVEL_W-1:0] lvl, adist_pkg::kind_t k);
    int v;
    int lv;
    int half;
    int quarter;
    int acc;
    v  = int'(s);
    lv = int'(lvl);
    if (!en) return s;
    case (k)
      adist_pkg::KIND_CLIP: begin
        half = (255 - 2 * lv) / 2;
        if (v > 127 + half) v = 127 + half;
        else if (v < 127 - half) v = 127 - half;
      end
      adist_pkg::KIND_OVERDRIVE: begin
        acc = (v - 127) * (1 + (lv * 9) / 255);
        if (acc > 100) acc = 100 + (acc - 100) / 4;
        else if (acc < -100) acc = -100 + (acc + 100) / 4;
        if (acc > 127) acc = 127;
        if (acc < -127) acc = -127;
        v = acc + 127;
      end
      adist_pkg::KIND_FUZZ: begin
        quarter = (255 - lv) / 4;
        if (v > 127 + quarter) v = 255;
        else if (v < 127 - quarter) v = 0;
      end
      default: ;
    endcase
    return adist_pkg::SAMPLE_W'(v);
  endfunction

  function automatic void take_write(logic [adist_pkg::INDEX_W-1:0] idx,
                                     logic [adist_pkg::LEVEL_W-1:0] d);
    case (idx)
      adist_pkg::REG_ENABLE: fx_enable = d[0];
      adist_pkg::REG_LEVEL:  if (int'(d) <= LEVEL_LIMIT) fx_level = d;
      adist_pkg::REG_KIND:   if (d[1:0] != KIND_BAD) fx_kind = adist_pkg::kind_t'(d[1:0]);
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [adist_pkg::INDEX_W-1:0] idx,
                           input logic [adist_pkg::LEVEL_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    take_write(idx, d);
    writes_done++;
  endtask

  // the prediction uses the register values in force, which stay put while samples flow
  task automatic send_sample(input logic [adist_pkg::SAMPLE_W-1:0] s,
                             input logic [adist_pkg::SAMPLE_W-1:0] want,
                             input logic known);
    int gap;
    if (gaps_on && $urandom_range(99) < 29) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (busy);
    pending_samples.push_back(known ? want : distort(s, fx_enable, fx_level, fx_kind));
  endtask

  // lower both channels and hold off until the pipeline is empty
  task automatic settle();
    @(negedge clk);
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    logic [adist_pkg::SAMPLE_W-1:0] want;
    if (!rst && done) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected transfer, sample_out %0d", $time, sample_out);
        faults++;
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (sample_out !== want) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want, sample_out);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d samples outstanding", $time, pending_samples.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [adist_pkg::SAMPLE_W-1:0] s;
    logic [adist_pkg::LEVEL_W-1:0]  lvl;
    logic [adist_pkg::LEVEL_W-1:0]  en_word;
    faults          = 0;
    samples_checked = 0;
    writes_done     = 0;
    cycles          = 0;
    gaps_on         = 1'b1;
    fx_enable       = 1'b0;
    fx_level        = adist_pkg::LEVEL_RESET;
    fx_kind         = adist_pkg::KIND_CLIP;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].op == STEP_WRITE) begin
        settle();
        write_reg(script[i].idx, script[i].data);
        settle();
      end else begin
        send_sample(script[i].smp, script[i].want, script[i].known);
      end
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      // two phases run back to back with no gaps at all
      gaps_on = !(p == 4 || p == 5);
      case (p % 5)
        0:       lvl = 7'd0;
        1:       lvl = 7'd100;
        2:       lvl = adist_pkg::LEVEL_W'($urandom_range(0, 127));
        default: lvl = adist_pkg::LEVEL_W'($urandom_range(0, 100));
      endcase
      en_word = adist_pkg::LEVEL_W'($urandom_range(0, 127));
      en_word[0] = ($urandom_range(99) < 85);
      write_reg(adist_pkg::REG_KIND, adist_pkg::LEVEL_W'(p % 3));
      write_reg(adist_pkg::REG_LEVEL, lvl);
      write_reg(adist_pkg::REG_ENABLE, en_word);
      write_reg(adist_pkg::INDEX_W'($urandom_range(0, 3)),
                adist_pkg::LEVEL_W'($urandom_range(0, 127)));
      settle();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 10) s = $urandom_range(1) ? 8'd255 : 8'd0;
        else s = adist_pkg::SAMPLE_W'($urandom_range(0, 255));
        send_sample(s, '0, 1'b0);
      end
      settle();
    end

    $display("checked %0d samples over %0d register writes, clip, overdrive and fuzz,",
             samples_checked, writes_done);
    $display("levels 0 to 100, bypass, and ignored level, kind and index writes");
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== audio_distortion_effect.f =====
rtl/core/adist_pkg.sv
rtl/core/adist_cfg.sv
rtl/core/adist_shaper.sv
rtl/core/audio_distortion_effect.sv
tb/audio_distortion_effect_tb.sv
